>>> design/swmm_pkg.sv
// Shared constants and types for the sliding window min/max/mean block.
package swmm_pkg;

    // Width of the window length register and of the held-sample count.
    localparam int WLEN_BITS = 7;
    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd64;

    // Per-cycle commands that every cell of the sample chain obeys.
    typedef struct packed {
        logic shift;   // take a new beat in at the head, every cell moves one place back
        logic rotate;  // circular move toward the head, the head wraps to the tail
    } t_cell_ctrl;

endpackage

>>> design/swmm_cell.sv
// One storage cell of the sample chain, holding a single sample.
module swmm_cell
    import swmm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  t_cell_ctrl             i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_shift_in,
    input  logic [SAMPLE_BITS-1:0] i_rot_in,
    output logic [SAMPLE_BITS-1:0] o_sample
);

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] n_sample;

    always_comb begin
        n_sample = r_sample;
        if (i_ctrl.shift) begin
            n_sample = i_shift_in;
        end else if (i_ctrl.rotate) begin
            n_sample = i_rot_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    assign o_sample = r_sample;

endmodule

>>> design/swmm_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
module swmm_div
    import swmm_pkg::*;
#(
    parameter int Q_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [Q_BITS+WLEN_BITS-1:0] i_dividend,
    input  logic [WLEN_BITS-1:0]        i_divisor,
    output logic                        o_done,
    output logic [Q_BITS-1:0]           o_quotient
);

    localparam int CB = $clog2(Q_BITS + 1);
    localparam logic [CB-1:0] STEPS = CB'(Q_BITS);

    // The dividend is below divisor * 2**Q_BITS, so its upper bits already
    // form a valid partial remainder and only Q_BITS steps are needed.
    logic [WLEN_BITS-1:0] r_rem;
    logic [Q_BITS-1:0]    r_quo;
    logic [WLEN_BITS-1:0] r_div;
    logic [CB-1:0]        r_cnt;
    logic                 r_done;

    logic [WLEN_BITS:0] w_trial;
    logic [WLEN_BITS:0] w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_quo[Q_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_rem  <= i_dividend[Q_BITS+WLEN_BITS-1:Q_BITS];
                r_quo  <= i_dividend[Q_BITS-1:0];
                r_div  <= i_divisor;
                r_cnt  <= STEPS;
                r_done <= 1'b0;
            end else if (r_cnt != '0) begin
                r_rem  <= w_ge ? w_diff[WLEN_BITS-1:0] : w_trial[WLEN_BITS-1:0];
                r_quo  <= {r_quo[Q_BITS-2:0], w_ge};
                r_cnt  <= r_cnt - CB'(1);
                r_done <= (r_cnt == CB'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> design/sliding_window_min_max_mean.sv
// A sample is accepted only in the idle state: the block takes no new sample until the
// previous one has gone through one full rotation of the sample chain, the bit-per-cycle
// mean divider and the hand-over to the output register.
// A finished result waits in the output register, so the next sample is taken meanwhile.
// Reset (synchronous, active low) empties the window and sets the window length to 64;
// the sample cells themselves are not cleared and no clearing pass is needed.
module sliding_window_min_max_mean
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration port: window length.
    input  logic                   i_cfg_wr_en,
    input  logic [WLEN_BITS-1:0]   i_cfg_wr_data,
    // Sample input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_speed_sample,
    // Result output channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0] o_window_minimum,
    output logic [SAMPLE_BITS-1:0] o_window_maximum,
    output logic [SAMPLE_BITS-1:0] o_window_mean,
    output logic [WLEN_BITS-1:0]   o_samples_held
);

    localparam int IDX_BITS = $clog2(WINDOW_MAX);
    localparam int SUM_BITS = SAMPLE_BITS + WLEN_BITS;
    localparam int KB       = (IDX_BITS > WLEN_BITS) ? IDX_BITS : WLEN_BITS;
    // The count can never exceed what the window length register can hold.
    localparam int WMAX_CLIP = (WINDOW_MAX > (2**WLEN_BITS - 1)) ? (2**WLEN_BITS - 1)
                                                                   : WINDOW_MAX;
    localparam logic [WLEN_BITS-1:0] WMAX_W = WLEN_BITS'(WMAX_CLIP);
    localparam logic [IDX_BITS-1:0]  K_LAST = IDX_BITS'(WINDOW_MAX - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIVGO,
        S_DIV,
        S_PUSH
    } t_state;

    t_state                 r_state;
    logic [WLEN_BITS-1:0]   r_window_length;
    logic [WLEN_BITS-1:0]   r_fill;
    logic [WLEN_BITS-1:0]   r_n;
    logic [IDX_BITS-1:0]    r_k;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_min;
    logic [SAMPLE_BITS-1:0] r_out_max;
    logic [SAMPLE_BITS-1:0] r_out_mean;
    logic [WLEN_BITS-1:0]   r_out_held;

    logic                   w_in_accept;
    logic                   w_out_accept;
    logic                   w_push;
    logic [WLEN_BITS-1:0]   w_eff_window;
    logic [WLEN_BITS-1:0]   w_clip;
    logic [WLEN_BITS-1:0]   n_fill;
    logic [SAMPLE_BITS-1:0] w_head;
    logic                   w_in_window;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [SAMPLE_BITS-1:0] w_quotient;
    t_cell_ctrl             w_ctrl;
    logic [SAMPLE_BITS-1:0] w_cell_q [WINDOW_MAX];

    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_accept = r_out_valid && !i_out_stall;
    // The finished result moves into the output register when that register
    // is free or is being emptied in the same cycle.
    assign w_push       = (r_state == S_PUSH) && (!r_out_valid || !i_out_stall);

    // A zero window length means one sample; lengths past the chain saturate.
    always_comb begin
        if (r_window_length == '0) begin
            w_eff_window = WLEN_BITS'(1);
        end else if (r_window_length > WMAX_W) begin
            w_eff_window = WMAX_W;
        end else begin
            w_eff_window = r_window_length;
        end
    end

    // A shortened window cuts the count first; the count then grows by one per
    // sample until it reaches the window length. Dropped samples never return.
    always_comb begin
        w_clip = (r_fill > w_eff_window) ? w_eff_window : r_fill;
        n_fill = (w_clip < w_eff_window) ? (w_clip + WLEN_BITS'(1)) : w_clip;
    end

    // The chain keeps the newest sample at the head. A new beat shifts every
    // cell one place back and drops the oldest. During the scan the chain
    // rotates toward the head once around, so the head shows the k-th newest
    // sample on scan cycle k and the chain ends up exactly where it began.
    always_comb begin
        w_ctrl.shift  = w_in_accept;
        w_ctrl.rotate = (r_state == S_SCAN);
    end

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swmm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_shift_in ((g == 0) ? i_speed_sample : w_cell_q[(g + WINDOW_MAX - 1) % WINDOW_MAX]),
            .i_rot_in   (w_cell_q[(g + 1) % WINDOW_MAX]),
            .o_sample   (w_cell_q[g])
        );
    end

    assign w_head      = w_cell_q[0];
    assign w_in_window = (KB'(r_k) < KB'(r_n));
    assign w_div_start = (r_state == S_DIVGO);

    // The mean is the sum over the held samples divided by their count.
    swmm_div #(
        .Q_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Sequencer: accept, scan the chain, divide, then hand the result to the
    // output register as soon as that register is free or being emptied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_window_length <= WLEN_RESET;
            r_fill          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window_length <= i_cfg_wr_data;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (w_out_accept) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_fill  <= n_fill;
                        r_n     <= n_fill;
                        r_k     <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_sum   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_in_window) begin
                        if (w_head < r_min) begin
                            r_min <= w_head;
                        end
                        if (w_head > r_max) begin
                            r_max <= w_head;
                        end
                        r_sum <= r_sum + SUM_BITS'(w_head);
                    end
                    r_k <= r_k + IDX_BITS'(1);
                    if (r_k == K_LAST) begin
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_push) begin
                        r_out_min   <= r_min;
                        r_out_max   <= r_max;
                        r_out_mean  <= w_quotient;
                        r_out_held  <= r_n;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_window_minimum = r_out_min;
    assign o_window_maximum = r_out_max;
    assign o_window_mean    = r_out_mean;
    assign o_samples_held   = r_out_held;

`ifndef NO_ASSERTIONS
    // Only one sample is ever in flight.
    a_one_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("input accepted while a sample is still being processed");

    // A result always covers at least one sample and never more than the chain holds.
    a_held_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_held != '0) && (r_out_held <= WMAX_W))
        else $error("sample count of a result out of range");

    // The mean lies between the minimum and the maximum of the same window.
    a_stats_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_min <= r_out_mean) && (r_out_mean <= r_out_max))
        else $error("minimum, mean and maximum out of order");

    // The divider finishes before the result is pushed out.
    a_div_before_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && !w_div_done |=> (r_state == S_DIV))
        else $error("sequencer left the divide step before the quotient was ready");
`endif

endmodule

>>> bench/tb_sliding_window_min_max_mean.sv
// Self-checking testbench for the sliding window min/max/mean block.
module tb_sliding_window_min_max_mean;
    import swmm_pkg::*;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    // One rotation of the sample chain plus the serial divider.
    localparam int LATENCY     = WINDOW_MAX + SAMPLE_BITS + 4;
    // The long receiver hold-off used to fill the block and back up its input.
    localparam int HOLD_CYCLES = 1500;
    // No correct run goes this long without a single beat on either channel.
    localparam int IDLE_LIMIT  = 10000;
    localparam int RANDOM_ITEMS = 760;
    // Depth of the table of predicted results; the block never holds more than two.
    localparam int EXP_DEPTH   = 8;

    // One result beat, with the fields in the order the block reports them.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] wmin;
        logic [SAMPLE_BITS-1:0] wmax;
        logic [SAMPLE_BITS-1:0] wmean;
        logic [WLEN_BITS-1:0]   held;
    } t_window_stats;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [WLEN_BITS-1:0]   i_cfg_wr_data = '0;
    logic                   i_in_valid = 1'b0;
    logic [SAMPLE_BITS-1:0] i_speed_sample = '0;
    logic                   i_out_stall = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [SAMPLE_BITS-1:0] o_window_minimum;
    logic [SAMPLE_BITS-1:0] o_window_maximum;
    logic [SAMPLE_BITS-1:0] o_window_mean;
    logic [WLEN_BITS-1:0]   o_samples_held;

    sliding_window_min_max_mean #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_speed_sample   (i_speed_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_window_minimum (o_window_minimum),
        .o_window_maximum (o_window_maximum),
        .o_window_mean    (o_window_mean),
        .o_samples_held   (o_samples_held)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the window state. The ring starts undefined, which is fine
    // because only entries written since reset are ever read back.
    logic [SAMPLE_BITS-1:0] ring_copy [WINDOW_MAX];
    int unsigned            next_slot = 0;
    int unsigned            held_count = 0;
    logic [WLEN_BITS-1:0]   window_len_reg = WLEN_RESET;

    // Predicted results in order; the sender adds at exp_tail, the checker takes
    // from exp_head, and the two are equal when nothing is outstanding.
    t_window_stats expected_stats [EXP_DEPTH];
    int unsigned   exp_head = 0;
    int unsigned   exp_tail = 0;
    int unsigned   mismatches = 0;
    int unsigned   out_beats = 0;
    int unsigned   hold_requests = 0;
    int unsigned   idle_cycles = 0;
    bit            no_idle = 1'b0;
    int unsigned   random_sent = 0;

    // Works out the statistics that one accepted sample must produce and records them.
    // The window length is clamped the same way the block does: zero acts as one,
    // and anything past the ring depth acts as the full ring.
    task automatic predict_window_stats(input logic [SAMPLE_BITS-1:0] sample);
        int unsigned            span;
        int unsigned            slot;
        int unsigned            total;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        t_window_stats          stats;
        if (window_len_reg == 0) begin
            span = 1;
        end else if (window_len_reg > WINDOW_MAX) begin
            span = WINDOW_MAX;
        end else begin
            span = window_len_reg;
        end
        ring_copy[next_slot] = sample;
        next_slot = (next_slot + 1) % WINDOW_MAX;
        // A shortened window cuts the count first; a longer one regrows it by one per beat.
        if (held_count > span) held_count = span;
        if (held_count < span) held_count++;
        slot = next_slot;
        lo = '1;
        hi = '0;
        total = 0;
        for (int k = 0; k < held_count; k++) begin
            slot = (slot == 0) ? WINDOW_MAX - 1 : slot - 1;
            if (ring_copy[slot] < lo) lo = ring_copy[slot];
            if (ring_copy[slot] > hi) hi = ring_copy[slot];
            total += ring_copy[slot];
        end
        stats.wmin  = lo;
        stats.wmax  = hi;
        stats.wmean = SAMPLE_BITS'(total / held_count);
        stats.held  = WLEN_BITS'(held_count);
        if (exp_tail - exp_head >= EXP_DEPTH) begin
            $error("more results outstanding than the block can hold");
            mismatches++;
        end
        expected_stats[exp_tail % EXP_DEPTH] = stats;
        exp_tail++;
    endtask

    // Offers one sample beat after a random gap and returns at the falling edge
    // after it was taken. Valid is left high so back-to-back beats need no dip.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_speed_sample <= sample;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_window_stats(sample);
        @(negedge i_clk);
    endtask

    // Writes the window length once every outstanding result has come back.
    // Every beat yields a result here, so nothing outstanding means the block is idle.
    task automatic write_window_length(input logic [WLEN_BITS-1:0] len);
        i_in_valid <= 1'b0;
        while (exp_tail != exp_head) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        window_len_reg = len;
    endtask

    // Biases samples toward the ends of the range so that ties and extremes occur often.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_BITS'($urandom_range(0, 15));
            3:       return {SAMPLE_BITS{1'b1}} - SAMPLE_BITS'($urandom_range(0, 15));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Result checker: every accepted result beat must match the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_window_stats want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_beats <= out_beats + 1;
            if (exp_tail == exp_head) begin
                $error("result beat with no sample waiting for it");
                mismatches++;
            end else begin
                want = expected_stats[exp_head % EXP_DEPTH];
                exp_head++;
                if (o_window_minimum !== want.wmin) begin
                    $error("window_minimum: expected %0d, got %0d", want.wmin, o_window_minimum);
                    mismatches++;
                end
                if (o_window_maximum !== want.wmax) begin
                    $error("window_maximum: expected %0d, got %0d", want.wmax, o_window_maximum);
                    mismatches++;
                end
                if (o_window_mean !== want.wmean) begin
                    $error("window_mean: expected %0d, got %0d", want.wmean, o_window_mean);
                    mismatches++;
                end
                if (o_samples_held !== want.held) begin
                    $error("samples_held: expected %0d, got %0d", want.held, o_samples_held);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: after each result beat it stalls for a freshly drawn number of cycles.
    // A hold request, raised at a rising edge by a test, makes it stall for a long
    // stretch that it counts down itself.
    always @(negedge i_clk) begin : result_receiver
        int unsigned holds_served;
        int unsigned beats_seen;
        int unsigned hold_left;
        int unsigned stall_left;
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (out_beats != beats_seen) begin
            beats_seen = out_beats;
            stall_left = no_idle ? 0 : $urandom_range(0, 17);
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: a run that moves no beat on either channel for too long has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Extremes of the sample field under the reset window of 64. Between them these
    // values set and clear every bit of the input.
    task automatic test_extreme_samples();
        send_sample('0);
        send_sample('1);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0001);
        send_sample(16'hFFFE);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        send_sample('1);
        send_sample('0);
    endtask

    // A window length of zero must behave as a window of one sample.
    task automatic test_window_zero();
        write_window_length('0);
        send_sample('1);
        send_sample('0);
        send_sample(16'h1234);
    endtask

    // A window length past the ring depth saturates; the random phases carry it further.
    task automatic test_window_above_max();
        write_window_length('1);
        send_sample(16'hFFF0);
        send_sample(16'h000F);
    endtask

    // Shrinking the window cuts the count at once; growing it regrows one per beat
    // without bringing back samples that already dropped out.
    task automatic test_resize_at_run_time();
        write_window_length(7'd5);
        repeat (6) send_sample(pick_sample());
        write_window_length(7'd2);
        repeat (2) send_sample(pick_sample());
        write_window_length(7'd4);
        repeat (3) send_sample(pick_sample());
    endtask

    // Random phases, each with its own window setting and run length. Some phases
    // run with idling switched off on both sides.
    task automatic test_random_windows();
        logic [WLEN_BITS-1:0] len;
        int unsigned          count;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       len = 7'd1;
                1:       len = 7'd64;
                2:       len = '1;
                3:       len = '0;
                4:       len = 7'd65;
                5:       len = WLEN_BITS'($urandom_range(2, 8));
                6:       len = WLEN_BITS'($urandom_range(0, 127));
                default: len = WLEN_BITS'($urandom_range(1, 64));
            endcase
            write_window_length(len);
            @(posedge i_clk);
            no_idle = ($urandom_range(0, 3) == 0);
            @(negedge i_clk);
            count = $urandom_range(10, 90);
            repeat (count) send_sample(pick_sample());
            random_sent += count;
        end
        @(posedge i_clk);
        no_idle = 1'b0;
        @(negedge i_clk);
    endtask

    // The receiver holds off for a long stretch while samples keep coming, so the
    // block fills its output register and has to stall its own input.
    task automatic test_output_backpressure();
        write_window_length(7'd16);
        @(posedge i_clk);
        hold_requests++;
        @(negedge i_clk);
        repeat (20) send_sample(pick_sample());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extreme_samples();
        test_window_zero();
        test_window_above_max();
        test_resize_at_run_time();
        test_random_windows();
        test_output_backpressure();

        // Drain: wait for every prediction to be met, then give the block time to
        // show any stray beat before the verdict.
        i_in_valid <= 1'b0;
        while (exp_tail != exp_head) @(posedge i_clk);
        repeat (LATENCY + 16) @(posedge i_clk);
        if (mismatches == 0 && exp_tail == exp_head) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
